/* src/particle_table_aging_update_assert.svh */
// Assertion macros for the particle table block.
// Each macro takes a label, an antecedent and a consequent; clk and rst_n
// must be visible at the point of use.
`ifndef PARTICLE_TABLE_AGING_UPDATE_ASSERT_SVH
`define PARTICLE_TABLE_AGING_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define PTAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("particle table check failed");

// Next-cycle implication.
`define PTAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("particle table check failed");

`endif

/* src/ptau_pkg.sv */
// ----------------------------------------------------------------------------
// ptau_pkg
// Types, register codes and helpers shared by the particle table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptau_pkg;

  localparam int DEF_CAPACITY = 64;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_MAX_AGE  = 3'd0;
  localparam logic [2:0] CFG_DAMPING  = 3'd1;
  localparam logic [2:0] CFG_CLAMP_EN = 3'd2;
  localparam logic [2:0] CFG_X_LOWER  = 3'd3;
  localparam logic [2:0] CFG_X_UPPER  = 3'd4;
  localparam logic [2:0] CFG_Y_LOWER  = 3'd5;
  localparam logic [2:0] CFG_Y_UPPER  = 3'd6;

  localparam logic [23:0] RST_MAX_AGE  = 24'd32768;
  localparam logic [15:0] RST_DAMPING  = 16'd640;
  localparam logic        RST_CLAMP_EN = 1'b1;
  localparam logic [31:0] RST_X_LOWER  = 32'hFFFB_0000;
  localparam logic [31:0] RST_X_UPPER  = 32'h000A_0000;
  localparam logic [31:0] RST_Y_LOWER  = 32'hFFFB_0000;
  localparam logic [31:0] RST_Y_UPPER  = 32'h0005_0000;

  localparam logic        KIND_PUSH  = 1'b0;
  localparam logic [23:0] AGE_SAT    = 24'hFF_FFFF;
  localparam logic [7:0]  ALPHA_FULL = 8'hFF;

  // Multiplier lanes: three velocity damps, then three position moves
  localparam logic [2:0] LANE_VX = 3'd0;
  localparam logic [2:0] LANE_VY = 3'd1;
  localparam logic [2:0] LANE_VZ = 3'd2;
  localparam logic [2:0] LANE_PX = 3'd3;
  localparam logic [2:0] LANE_PY = 3'd4;
  localparam logic [2:0] LANE_PZ = 3'd5;

  typedef struct packed {
    logic        [23:0] max_age;
    logic        [15:0] damping;
    logic               clamp_en;
    logic signed [31:0] x_lo;
    logic signed [31:0] x_hi;
    logic signed [31:0] y_lo;
    logic signed [31:0] y_hi;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic        [23:0] age;
    logic        [31:0] color;
  } entry_t;

  typedef struct packed {
    logic       push;
    logic       tick_init;
    logic       rd_src;
    logic       load;
    logic       mul_issue;
    logic [2:0] mul_lane;
    logic       clamp_age;
    logic       retire;
    logic       div_start;
    logic       div_step;
    logic       write_back;
    logic       emit_init;
    logic       emit_rd;
    logic       emit_none;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic count_zero;
    logic expired;
    logic div_last;
    logic emit_done;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sh0_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -50'sh0_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [31:0] t;
    t = (v < lo) ? lo : v;
    t = (t > hi) ? hi : t;
    return t;
  endfunction

endpackage

`default_nettype wire

/* src/ptau_cfg.sv */
// ----------------------------------------------------------------------------
// ptau_cfg
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptau_cfg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [31:0]    cfg_data,
  output ptau_pkg::cfg_t      cfg
);
  import ptau_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_age  <= RST_MAX_AGE;
      cfg_r.damping  <= RST_DAMPING;
      cfg_r.clamp_en <= RST_CLAMP_EN;
      cfg_r.x_lo     <= RST_X_LOWER;
      cfg_r.x_hi     <= RST_X_UPPER;
      cfg_r.y_lo     <= RST_Y_LOWER;
      cfg_r.y_hi     <= RST_Y_UPPER;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_AGE:  cfg_r.max_age  <= cfg_data[23:0];
        CFG_DAMPING:  cfg_r.damping  <= cfg_data[15:0];
        CFG_CLAMP_EN: cfg_r.clamp_en <= cfg_data[0];
        CFG_X_LOWER:  cfg_r.x_lo     <= cfg_data;
        CFG_X_UPPER:  cfg_r.x_hi     <= cfg_data;
        CFG_Y_LOWER:  cfg_r.y_lo     <= cfg_data;
        CFG_Y_UPPER:  cfg_r.y_hi     <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/ptau_ctrl.sv */
// ----------------------------------------------------------------------------
// ptau_ctrl
// Sequencer: walks each entry through load, multiply, clamp, then divide and
// write-back, or retire if expired, then streams the survivors out.
// ----------------------------------------------------------------------------
`default_nettype none

module ptau_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic         in_kind,
  input  ptau_pkg::stat_t   stat,
  output ptau_pkg::cmd_t    cmd,
  output logic              busy
);
  import ptau_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WALK  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_APPLY = 4'd4;
  localparam logic [3:0] S_CLAMP = 4'd5;
  localparam logic [3:0] S_EVAL  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_DRAIN = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [2:0] lane_r, lane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lane_r  <= LANE_VX;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    lane_nxt  = lane_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_kind == KIND_PUSH) begin
            cmd.push = 1'b1;
          end else begin
            cmd.tick_init = 1'b1;
            state_nxt     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          if (stat.count_zero) begin
            cmd.emit_none = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.emit_init = 1'b1;
            state_nxt     = S_EMIT;
          end
        end else begin
          cmd.rd_src = 1'b1;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        lane_nxt  = LANE_VX;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.mul_lane  = lane_r;
        if (lane_r == LANE_PZ) begin
          state_nxt = S_APPLY;
        end else begin
          lane_nxt = lane_r + 3'd1;
        end
      end
      S_APPLY: state_nxt = S_CLAMP;  // last product lands this cycle
      S_CLAMP: begin
        cmd.clamp_age = 1'b1;
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        if (stat.expired) begin
          cmd.retire = 1'b1;
          state_nxt  = S_WALK;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_WB;
      end
      S_WB: begin
        cmd.write_back = 1'b1;
        state_nxt      = S_WALK;
      end
      S_EMIT: begin
        if (stat.emit_done) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.emit_rd = 1'b1;
        end
      end
      S_DRAIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

/* src/ptau_dp.sv */
// ----------------------------------------------------------------------------
// ptau_dp
// Datapath: particle memory, shared multiplier, clamp and age logic,
// alpha divider, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptau_dp #(
  parameter int CAPACITY = ptau_pkg::DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  ptau_pkg::cfg_t           cfg,
  input  ptau_pkg::cmd_t           cmd,
  output ptau_pkg::stat_t          stat,
  input  wire logic signed [31:0]  in_pos_x,
  input  wire logic signed [31:0]  in_pos_y,
  input  wire logic signed [31:0]  in_pos_z,
  input  wire logic signed [31:0]  in_vel_x,
  input  wire logic signed [31:0]  in_vel_y,
  input  wire logic signed [31:0]  in_vel_z,
  input  wire logic        [31:0]  in_color_in,
  input  wire logic        [15:0]  in_step_time,
  output logic                     out_valid,
  output logic                     out_accepted,
  output logic [CNT_W-1:0]         out_live_count,
  output logic                     out_particle_present,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic        [31:0]       out_color,
  output logic                     out_last
);
  import ptau_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // Table storage and read port
  entry_t mem [CAPACITY];
  entry_t rdata_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  logic [CNT_W-1:0] count_r, i_r, src_r, j_r;
  entry_t           ent_r;
  logic [15:0]      dt_r;
  logic [31:0]      k_r;
  logic [63:0]      prod_r;
  logic             neg_r, pvld_r;
  logic [2:0]       plane_r;
  logic [31:0]      rem_r;
  logic [7:0]       q_r;
  logic [2:0]       dbit_r;
  logic             pend_r, pend_last_r;

  logic   room;
  entry_t push_ent, wb_ent;
  logic [7:0] alpha;

  assign room = (count_r < CAP_CNT);

  always_comb begin
    push_ent.x     = in_pos_x;
    push_ent.y     = in_pos_y;
    push_ent.z     = in_pos_z;
    push_ent.vx    = in_vel_x;
    push_ent.vy    = in_vel_y;
    push_ent.vz    = in_vel_z;
    push_ent.age   = 24'd0;
    push_ent.color = in_color_in;
  end

  // A zero lifetime leaves every survivor fully opaque
  assign alpha = (cfg.max_age == 24'd0) ? ALPHA_FULL : q_r;

  always_comb begin
    wb_ent       = ent_r;
    wb_ent.color = {alpha, ent_r.color[23:0]};
  end

  assign mem_we    = (cmd.push && room) || cmd.write_back;
  assign mem_waddr = cmd.push ? count_r[IDX_W-1:0] : i_r[IDX_W-1:0];
  assign mem_wdata = cmd.push ? push_ent : wb_ent;
  assign mem_re    = cmd.rd_src || cmd.emit_rd;
  assign mem_raddr = cmd.rd_src ? src_r[IDX_W-1:0] : j_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // Multiplier issue: magnitude times factor, sign kept aside
  logic signed [31:0] mop;
  logic        [31:0] mag, fac;

  always_comb begin
    unique case (cmd.mul_lane)
      LANE_VX, LANE_PX: mop = ent_r.vx;
      LANE_VY, LANE_PY: mop = ent_r.vy;
      LANE_VZ, LANE_PZ: mop = ent_r.vz;
      default:          mop = ent_r.vx;
    endcase
    mag = mop[31] ? (~mop + 32'd1) : mop;
    fac = (cmd.mul_lane < LANE_PX) ? k_r : {16'd0, dt_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= cmd.mul_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_issue) begin
      prod_r  <= {32'd0, mag} * {32'd0, fac};
      neg_r   <= mop[31];
      plane_r <= cmd.mul_lane;
    end
  end

  // Product apply: damp subtracts the scaled velocity, move adds it
  logic               is_damp, sub;
  logic        [47:0] term;
  logic signed [31:0] base;
  logic signed [49:0] sum;
  logic signed [31:0] app;

  always_comb begin
    is_damp = (plane_r < LANE_PX);
    term    = is_damp ? {8'd0, prod_r[63:24]} : prod_r[63:16];
    unique case (plane_r)
      LANE_VX: base = ent_r.vx;
      LANE_VY: base = ent_r.vy;
      LANE_VZ: base = ent_r.vz;
      LANE_PX: base = ent_r.x;
      LANE_PY: base = ent_r.y;
      LANE_PZ: base = ent_r.z;
      default: base = ent_r.x;
    endcase
    sub = is_damp ^ neg_r;
    sum = sub ? ({{18{base[31]}}, base} - {2'b00, term})
              : ({{18{base[31]}}, base} + {2'b00, term});
    app = sat32(sum);
  end

  logic [24:0] age_sum;
  logic [23:0] age_nxt;

  assign age_sum = {1'b0, ent_r.age} + {9'd0, dt_r};
  assign age_nxt = age_sum[24] ? AGE_SAT : age_sum[23:0];

  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      ent_r <= rdata_r;
    end else if (pvld_r) begin
      unique case (plane_r)
        LANE_VX: ent_r.vx <= app;
        LANE_VY: ent_r.vy <= app;
        LANE_VZ: ent_r.vz <= app;
        LANE_PX: ent_r.x  <= app;
        LANE_PY: ent_r.y  <= app;
        LANE_PZ: ent_r.z  <= app;
        default: ;
      endcase
    end else if (cmd.clamp_age) begin
      if (cfg.clamp_en) begin
        ent_r.x <= clamp32(ent_r.x, cfg.x_lo, cfg.x_hi);
        ent_r.y <= clamp32(ent_r.y, cfg.y_lo, cfg.y_hi);
      end
      ent_r.age <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_init) begin
      dt_r <= in_step_time;
      k_r  <= {16'd0, cfg.damping} * {16'd0, in_step_time};
    end
  end

  // Alpha divider: one quotient bit per cycle, MSB first
  logic [23:0] life_left;
  logic [31:0] dsh;

  assign life_left = cfg.max_age - ent_r.age;
  assign dsh       = {8'd0, cfg.max_age} << dbit_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r  <= {life_left, 8'd0} - {8'd0, life_left};
      q_r    <= 8'd0;
      dbit_r <= 3'd7;
    end else if (cmd.div_step) begin
      if (rem_r >= dsh) begin
        rem_r        <= rem_r - dsh;
        q_r[dbit_r]  <= 1'b1;
      end
      dbit_r <= dbit_r - 3'd1;
    end
  end

  // Walk and emit indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      i_r         <= '0;
      src_r       <= '0;
      j_r         <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      if (cmd.push && room) count_r <= count_r + ONE_CNT;
      if (cmd.tick_init) begin
        i_r   <= '0;
        src_r <= '0;
      end
      // pull the last entry into the hole and process it next
      if (cmd.retire) begin
        count_r <= count_r - ONE_CNT;
        src_r   <= count_r - ONE_CNT;
      end
      if (cmd.write_back) begin
        i_r   <= i_r + ONE_CNT;
        src_r <= i_r + ONE_CNT;
      end
      if (cmd.emit_init) j_r <= '0;
      if (cmd.emit_rd) j_r <= j_r + ONE_CNT;
      pend_r      <= cmd.emit_rd;
      pend_last_r <= (j_r == count_r - ONE_CNT);
    end
  end

  always_comb begin
    stat.walk_done  = (i_r >= count_r);
    stat.count_zero = (count_r == '0);
    stat.expired    = (ent_r.age > cfg.max_age);
    stat.div_last   = (dbit_r == 3'd0);
    stat.emit_done  = (j_r >= count_r);
  end

  // Result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.push || cmd.emit_none || pend_r;
    end
  end

  logic               out_accepted_r, out_present_r, out_last_r;
  logic [CNT_W-1:0]   out_live_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic        [31:0] out_color_r;

  always_ff @(posedge clk) begin
    priority if (cmd.push) begin
      out_accepted_r <= room;
      out_live_r     <= room ? (count_r + ONE_CNT) : count_r;
      out_present_r  <= 1'b0;
      out_x_r        <= '0;
      out_y_r        <= '0;
      out_z_r        <= '0;
      out_color_r    <= '0;
      out_last_r     <= 1'b1;
    end else if (cmd.emit_none) begin
      out_accepted_r <= 1'b0;
      out_live_r     <= count_r;
      out_present_r  <= 1'b0;
      out_x_r        <= '0;
      out_y_r        <= '0;
      out_z_r        <= '0;
      out_color_r    <= '0;
      out_last_r     <= 1'b1;
    end else if (pend_r) begin
      out_accepted_r <= 1'b0;
      out_live_r     <= count_r;
      out_present_r  <= 1'b1;
      out_x_r        <= rdata_r.x;
      out_y_r        <= rdata_r.y;
      out_z_r        <= rdata_r.z;
      out_color_r    <= rdata_r.color;
      out_last_r     <= pend_last_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_accepted_r;
  assign out_live_count       = out_live_r;
  assign out_particle_present = out_present_r;
  assign out_x                = out_x_r;
  assign out_y                = out_y_r;
  assign out_z                = out_z_r;
  assign out_color            = out_color_r;
  assign out_last             = out_last_r;

endmodule

`default_nettype wire

/* src/particle_table_aging_update.sv */
// ----------------------------------------------------------------------------
// particle_table_aging_update
// Fixed-capacity particle table with push, timed update and swap-remove.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the in_ fields while busy is low to hand over one item.
//   kind 0 pushes a particle; its single result appears on the cycle after
//   the item, and busy stays low, so a push can follow every cycle.
//   kind 1 ticks the table by step_time. Each live entry goes through a read,
//   six products on the one shared 32x32 multiplier, clamp and age; a
//   survivor then goes through the alpha divider and a write-back, while an
//   expired entry is retired. Survivors are then read back from the table
//   one per cycle and delivered in index order once the walk ends. A tick
//   with no survivors gives one empty result.
//   Each result is on the out_ ports for one cycle, marked by out_valid;
//   the receiver cannot stall, so no result is ever held back.
//   Configuration is written through cfg_wr_en, cfg_index and cfg_data
//   while the block is idle.
//   Reset clears the table count and the sequencer; entry storage is left
//   as is and is only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_table_aging_update #(
  parameter int CAPACITY = ptau_pkg::DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_kind,
  input  wire logic signed [31:0]  in_pos_x,
  input  wire logic signed [31:0]  in_pos_y,
  input  wire logic signed [31:0]  in_pos_z,
  input  wire logic signed [31:0]  in_vel_x,
  input  wire logic signed [31:0]  in_vel_y,
  input  wire logic signed [31:0]  in_vel_z,
  input  wire logic        [31:0]  in_color_in,
  input  wire logic        [15:0]  in_step_time,
  input  wire logic                cfg_wr_en,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  output logic                     out_valid,
  output logic                     out_accepted,
  output logic [CNT_W-1:0]         out_live_count,
  output logic                     out_particle_present,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic        [31:0]       out_color,
  output logic                     out_last
);
  import ptau_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  ptau_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ptau_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  ptau_dp #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_pos_z             (in_pos_z),
    .in_vel_x             (in_vel_x),
    .in_vel_y             (in_vel_y),
    .in_vel_z             (in_vel_z),
    .in_color_in          (in_color_in),
    .in_step_time         (in_step_time),
    .out_valid            (out_valid),
    .out_accepted         (out_accepted),
    .out_live_count       (out_live_count),
    .out_particle_present (out_particle_present),
    .out_x                (out_x),
    .out_y                (out_y),
    .out_z                (out_z),
    .out_color            (out_color),
    .out_last             (out_last)
  );

`include "particle_table_aging_update_assert.svh"

  // a push always answers on the next cycle with a single final result
  `PTAU_ASSERT_NEXT(a_push_answer, rst_n && start && !busy && (in_kind == KIND_PUSH), out_valid && out_last)
  // results without a particle are always the final one of their item
  `PTAU_ASSERT_NOW(a_empty_last, out_valid && !out_particle_present, out_last)
  // a delivered particle implies a nonempty table
  `PTAU_ASSERT_NOW(a_present_count, out_valid && out_particle_present, out_live_count != '0)
  // the walk never writes back in the same cycle as a retire or a push
  `PTAU_ASSERT_NOW(a_wb_excl, cmd.write_back, !cmd.retire && !cmd.push)

endmodule

`default_nettype wire
